// ===== sv/gf2re_pkg.sv =====
// gf2re_pkg: shared types and constants for the GF(2) row elimination block.
// No dependencies; compiled first.
`default_nettype none

package gf2re_pkg;

	// Row width handled by the cell chain (2..64); one cell per column.
	localparam int ROW_BITS = 64;

	// Fixed field widths of the request and response payloads.
	localparam int DATA_W = 64;
	localparam int COL_W  = 6;

	localparam logic [DATA_W-1:0] ROW_MASK =
		(ROW_BITS >= DATA_W) ? {DATA_W{1'b1}} :
		((DATA_W'(1) << ROW_BITS) - DATA_W'(1));

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_LOAD   = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_ZERO      = 2'd0,
		ST_INSTALLED = 2'd1,
		ST_LOAD      = 2'd2,
		ST_READ      = 2'd3
	} status_t;

	// Token handed from cell to cell. hit marks that the outcome is settled
	// (row installed, loaded, or slot found); later cells pass it unchanged.
	typedef struct packed {
		logic              vld;
		logic [1:0]        op;
		logic [DATA_W-1:0] row;
		logic [COL_W-1:0]  col;
		logic              hit;
	} tok_t;

endpackage

`default_nettype wire

// ===== sv/gf2re_chan_if.sv =====
// gf2re_chan_if: valid/ready channel interfaces for requests and responses.
// Depends on gf2re_pkg for field widths.
`default_nettype none

interface gf2re_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [gf2re_pkg::DATA_W-1:0]  row_in;
	logic [gf2re_pkg::COL_W-1:0]   slot_index;

	modport source (output valid, op, row_in, slot_index, input ready);
	modport sink   (input valid, op, row_in, slot_index, output ready);
endinterface

interface gf2re_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [gf2re_pkg::COL_W-1:0]   pivot_column;
	logic [gf2re_pkg::DATA_W-1:0]  row_out;
	logic                          slot_valid;

	modport source (output valid, status, pivot_column, row_out, slot_valid, input ready);
	modport sink   (input valid, status, pivot_column, row_out, slot_valid, output ready);
endinterface

`default_nettype wire

// ===== sv/gf2re_cell.sv =====
// gf2re_cell: one column of the elimination chain; holds the eliminator slot
// for its column and registers the token for the next cell. Uses gf2re_pkg.
`default_nettype none

module gf2re_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [gf2re_pkg::COL_W-1:0]   cell_col,
	input  wire gf2re_pkg::tok_t               tok_i,
	output gf2re_pkg::tok_t                    tok_o
);

	logic [gf2re_pkg::DATA_W-1:0] elim_q;
	logic                         slot_vld_q;
	logic                         tok_vld_q;
	gf2re_pkg::tok_t              tok_q;
	gf2re_pkg::tok_t              nxt;
	logic                         wr;

	always_comb begin
		nxt = tok_i;
		wr  = 1'b0;
		if (tok_i.vld && !tok_i.hit) begin
			case (tok_i.op)
				gf2re_pkg::OP_REDUCE: begin
					// lower columns are already clear, so bit cell_col is the lead
					if (tok_i.row[cell_col]) begin
						if (slot_vld_q) begin
							nxt.row = tok_i.row ^ elim_q;
						end else begin
							wr      = 1'b1;
							nxt.hit = 1'b1;
							nxt.col = cell_col;
						end
					end
				end
				gf2re_pkg::OP_LOAD: begin
					// first set bit seen along the chain is the lead column
					if (tok_i.row[cell_col]) begin
						wr      = 1'b1;
						nxt.hit = 1'b1;
						nxt.col = cell_col;
					end
				end
				gf2re_pkg::OP_READ: begin
					if (tok_i.col == cell_col && slot_vld_q) begin
						nxt.hit = 1'b1;
						nxt.row = elim_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q  <= 1'b0;
			slot_vld_q <= 1'b0;
		end else if (en) begin
			tok_vld_q <= nxt.vld;
			if (wr) begin
				slot_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nxt;
			if (wr) begin
				elim_q <= tok_i.row;
			end
		end
	end

	always_comb begin
		tok_o     = tok_q;
		tok_o.vld = tok_vld_q;
	end

endmodule

`default_nettype wire

// ===== sv/gf2_row_elimination_top.sv =====
// gf2_row_elimination_top: GF(2) row elimination over a chain of column cells.
// Depends on gf2re_pkg, gf2re_chan_if and gf2re_cell.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | op, row_in, slot_index
//   rsp     | out | valid/ready | status, pivot_column, row_out, slot_valid
//
// A request walks the chain of ROW_BITS cells, one cell per cycle while the
// chain is not held; each cell owns the eliminator slot of its column, and the
// next request is accepted only once the previous one has left the chain.
// Reset clears all slot valid marks at once; slot contents need no clearing.
// One request is in the chain at a time. The response register lets a new
// request enter while the previous response waits; a stalled response
// freezes the chain only when the next token would need that register.
`default_nettype none

module gf2_row_elimination_top (
	input  wire logic clk,
	input  wire logic arst_n,
	gf2re_req_if.sink   req,
	gf2re_rsp_if.source rsp
);

	localparam int NC = gf2re_pkg::ROW_BITS;

	gf2re_pkg::tok_t tok [NC+1];
	logic [NC-1:0]   tok_vld;

	logic busy_q;
	logic chain_en;
	logic accept;
	logic retire;

	logic                            rsp_vld_q;
	logic [1:0]                      status_q;
	logic [gf2re_pkg::COL_W-1:0]     pivot_q;
	logic [gf2re_pkg::DATA_W-1:0]    row_out_q;
	logic                            slot_vld_q;

	logic [1:0]                      f_status;
	logic [gf2re_pkg::COL_W-1:0]     f_pivot;
	logic [gf2re_pkg::DATA_W-1:0]    f_row;
	logic                            f_slot_vld;

	// Chain holds only while the token at its end waits on a full response register.
	assign chain_en  = !tok[NC].vld || !rsp_vld_q || rsp.ready;
	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;
	assign retire    = tok[NC].vld && chain_en;

	// Entry token: rows are masked to ROW_BITS; reads start with an empty row
	// and carry the slot index in col.
	always_comb begin
		tok[0].vld = accept;
		tok[0].op  = req.op;
		tok[0].hit = 1'b0;
		if (req.op == gf2re_pkg::OP_READ) begin
			tok[0].row = '0;
			tok[0].col = req.slot_index;
		end else begin
			tok[0].row = req.row_in & gf2re_pkg::ROW_MASK;
			tok[0].col = '0;
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_cell
		gf2re_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (chain_en),
			.cell_col (gf2re_pkg::COL_W'(g)),
			.tok_i    (tok[g]),
			.tok_o    (tok[g+1])
		);
		assign tok_vld[g] = tok[g+1].vld;
	end

	// Response formatting from the token leaving the last cell.
	always_comb begin
		f_status   = gf2re_pkg::ST_LOAD;
		f_pivot    = '0;
		f_row      = '0;
		f_slot_vld = 1'b0;
		case (tok[NC].op)
			gf2re_pkg::OP_REDUCE: begin
				if (tok[NC].hit) begin
					f_status   = gf2re_pkg::ST_INSTALLED;
					f_pivot    = tok[NC].col;
					f_row      = tok[NC].row;
					f_slot_vld = 1'b1;
				end else begin
					f_status = gf2re_pkg::ST_ZERO;
				end
			end
			gf2re_pkg::OP_LOAD: begin
				if (tok[NC].hit) begin
					f_pivot    = tok[NC].col;
					f_row      = tok[NC].row;
					f_slot_vld = 1'b1;
				end
			end
			gf2re_pkg::OP_READ: begin
				f_status   = gf2re_pkg::ST_READ;
				f_pivot    = tok[NC].col;
				f_row      = tok[NC].hit ? tok[NC].row : '0;
				f_slot_vld = tok[NC].hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (retire) begin
				busy_q <= 1'b0;
			end
			if (retire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			status_q   <= f_status;
			pivot_q    <= f_pivot;
			row_out_q  <= f_row;
			slot_vld_q <= f_slot_vld;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.status       = status_q;
	assign rsp.pivot_column = pivot_q;
	assign rsp.row_out      = row_out_q;
	assign rsp.slot_valid   = slot_vld_q;

`ifndef SYNTH
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one request in the cell chain");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while chain busy");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_vld == '0))
		else $error("token in chain while not busy");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == gf2re_pkg::ST_ZERO) |->
			(rsp.row_out == '0 && !rsp.slot_valid && rsp.pivot_column == '0))
		else $error("dependent row response not cleared");

	a_install_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == gf2re_pkg::ST_INSTALLED) |->
			rsp.row_out[rsp.pivot_column])
		else $error("installed row lacks its pivot bit");
`endif

endmodule

`default_nettype wire

// ===== dv/gf2re_outcome_checker.sv =====
// gf2re_outcome_checker: watches the request and response channels of the GF(2)
// row elimination block, predicts each response and compares it field by field.
// Depends on gf2re_pkg and gf2re_chan_if.
`timescale 1ns / 100ps

module gf2re_outcome_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gf2re_req_if        req,
	gf2re_rsp_if        rsp,
	output int unsigned mismatch_count,
	output int unsigned pending_results
);
	import gf2re_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [COL_W-1:0]  pivot;
		logic [DATA_W-1:0] row;
		logic              slot_vld;
	} outcome_t;

	// Shadow eliminator table
	logic [DATA_W-1:0] elim_row [2**COL_W];
	logic              elim_vld [2**COL_W];

	outcome_t predicted_outcomes [$];
	outcome_t oldest;

	function automatic logic [COL_W-1:0] lowest_set(input logic [DATA_W-1:0] r);
		int c;
		c = 0;
		while (c < DATA_W - 1 && !r[c])
			c++;
		return COL_W'(c);
	endfunction

	// Updates the shadow table and returns the response the request must produce.
	function automatic outcome_t eliminate(input logic [1:0] op, input logic [DATA_W-1:0] row_in,
		input logic [COL_W-1:0] idx);
		outcome_t o;
		logic [DATA_W-1:0] r;
		logic [COL_W-1:0] c;
		r = row_in & ROW_MASK;
		o.status   = ST_LOAD;
		o.pivot    = '0;
		o.row      = '0;
		o.slot_vld = 1'b0;
		case (op)
		OP_REDUCE: begin
			o.status = ST_ZERO;
			for (int s = 0; s < ROW_BITS && r != '0 && o.status == ST_ZERO; s++) begin
				c = lowest_set(r);
				if (elim_vld[c]) begin
					r ^= elim_row[c];
				end else begin
					elim_row[c] = r;
					elim_vld[c] = 1'b1;
					o.status    = ST_INSTALLED;
					o.pivot     = c;
					o.row       = r;
					o.slot_vld  = 1'b1;
				end
			end
		end
		OP_LOAD: begin
			if (r != '0) begin
				c = lowest_set(r);
				elim_row[c] = r;
				elim_vld[c] = 1'b1;
				o.pivot     = c;
				o.row       = r;
				o.slot_vld  = 1'b1;
			end
		end
		OP_READ: begin
			o.status = ST_READ;
			o.pivot  = idx;
			if (elim_vld[idx]) begin
				o.row      = elim_row[idx];
				o.slot_vld = 1'b1;
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2**COL_W; i++)
				elim_vld[i] = 1'b0;
			predicted_outcomes.delete();
			mismatch_count  = 0;
			pending_results = 0;
		end else begin
			// response first: it can never belong to a request accepted at this edge
			if (rsp.valid && rsp.ready) begin
				if (predicted_outcomes.size() == 0) begin
					$error("response with no request outstanding");
					mismatch_count++;
				end else begin
					oldest = predicted_outcomes.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.pivot_column !== oldest.pivot) begin
						$error("pivot_column: expected %0d, got %0d", oldest.pivot,
							rsp.pivot_column);
						mismatch_count++;
					end
					if (rsp.row_out !== oldest.row) begin
						$error("row_out: expected %h, got %h", oldest.row, rsp.row_out);
						mismatch_count++;
					end
					if (rsp.slot_valid !== oldest.slot_vld) begin
						$error("slot_valid: expected %0d, got %0d", oldest.slot_vld,
							rsp.slot_valid);
						mismatch_count++;
					end
				end
			end
			if (req.valid && req.ready)
				predicted_outcomes.push_back(eliminate(req.op, req.row_in, req.slot_index));
			pending_results = predicted_outcomes.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// testbench: top of the GF(2) row elimination bench; drives requests, stalls
// responses and prints the verdict. Depends on gf2re_pkg, gf2re_chan_if,
// gf2_row_elimination_top and gf2re_outcome_checker.
`timescale 1ns / 100ps

module testbench;
	import gf2re_pkg::*;

	// op code the block must ignore
	localparam logic [1:0] OP_UNDEF = 2'd3;

	localparam int RANDOM_REQUESTS = 1880;
	localparam int QUIET_TAIL      = 150;   // last requests run with no idling at all
	localparam int DRAIN_EVERY     = 400;   // sender holds off until the block is empty
	localparam int CYCLE_LIMIT     = 1_000_000;

	logic        clk;
	logic        arst_n;
	bit          quiet;
	int          idle_odds;          // sender gap before 1 in idle_odds requests; 0 = none
	int unsigned mismatch_count;
	int unsigned pending_results;
	int unsigned cycle_count = 0;

	// recent reduce/load rows, mixed together to make dependent rows
	logic [DATA_W-1:0] row_history [$];

	gf2re_req_if req();
	gf2re_rsp_if rsp();

	gf2_row_elimination_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	gf2re_outcome_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses a response.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Response side: ready high for a random stretch, then a stall with ready low.
	// In the quiet tail ready just stays high.
	initial begin
		int span;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (quiet) begin
				@(negedge clk);
				rsp.ready <= 1'b1;
			end else begin
				span = $urandom_range(1, 40);
				@(negedge clk);
				rsp.ready <= 1'b1;
				repeat (span - 1) @(negedge clk);
				span = $urandom_range(1, 15);
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (span - 1) @(negedge clk);
			end
		end
	end

	// Present one request at a falling edge, optionally after an idle burst, and
	// hold it until it is accepted. valid stays high into the next request when
	// there is no gap, so it is never lowered and raised in the same step.
	task automatic issue(input logic [1:0] op, input logic [DATA_W-1:0] row,
		input logic [COL_W-1:0] idx);
		int gap;
		gap = 0;
		if (idle_odds != 0 && !quiet && $urandom_range(0, idle_odds - 1) == 0)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid      <= 1'b1;
		req.op         <= op;
		req.row_in     <= row;
		req.slot_index <= idx;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (op == OP_REDUCE || op == OP_LOAD) begin
			row_history.push_back(row);
			if (row_history.size() > 24)
				void'(row_history.pop_front());
		end
	endtask

	// Drop valid and wait until every outstanding response has come back.
	task automatic hold_until_settled();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Random row with varied density; often the low columns are cleared so the
	// leading column lands anywhere and high slots fill too.
	function automatic logic [DATA_W-1:0] shaped_row();
		logic [DATA_W-1:0] r;
		int k;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
		0: begin
			r &= {$urandom, $urandom};
		end
		1: begin
			r = (DATA_W'(1) << $urandom_range(0, DATA_W - 1)) |
				(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
		end
		2: begin
			r &= {$urandom, $urandom} & {$urandom, $urandom};
		end
		default: ;
		endcase
		k = $urandom_range(0, DATA_W - 1);
		if ($urandom_range(0, 1) == 1)
			r &= ~((DATA_W'(1) << k) - DATA_W'(1));
		return r;
	endfunction

	initial begin
		int kind;
		logic [DATA_W-1:0] mix;
		arst_n         = 1'b0;
		quiet          = 1'b0;
		idle_odds      = 4;
		req.valid      = 1'b0;
		req.op         = OP_REDUCE;
		req.row_in     = '0;
		req.slot_index = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		issue(OP_READ,   '0, 6'd0);                        // empty slot, lowest index
		issue(OP_READ,   '1, 6'd63);                       // empty slot, top index, row ignored
		issue(OP_UNDEF,  '1, 6'd63);                       // undefined op is ignored
		issue(OP_LOAD,   '0, 6'd0);                        // zero load is ignored
		issue(OP_REDUCE, '0, 6'd0);                        // zero row reduces to zero at once
		issue(OP_REDUCE, 64'h0000_0000_0000_0001, 6'd0);   // installs at column 0
		issue(OP_REDUCE, 64'h0000_0000_0000_0001, 6'd0);   // now dependent
		issue(OP_REDUCE, 64'h0000_0000_0000_0003, 6'd0);   // one XOR, installs at column 1
		issue(OP_REDUCE, 64'h8000_0000_0000_0000, 6'd0);   // top column
		issue(OP_REDUCE, '1, 6'd0);                        // all ones: XOR chain then install
		issue(OP_LOAD,   64'h4000_0000_0000_0000, 6'd63);  // direct load at column 62
		issue(OP_LOAD,   64'hC000_0000_0000_0000, 6'd0);   // overwrite of an occupied slot
		issue(OP_READ,   '0, 6'd62);
		issue(OP_READ,   '0, 6'd63);
		issue(OP_READ,   '0, 6'd1);
		issue(OP_REDUCE, 64'h5555_5555_5555_5555, 6'd63);
		issue(OP_LOAD,   '1, 6'd0);                        // overwrite column 0 with all ones
		issue(OP_REDUCE, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
		issue(OP_REDUCE, 64'hFFFF_FFFF_0000_0000, 6'd0);
		issue(OP_READ,   '0, 6'd0);
		issue(OP_UNDEF,  '0, 6'd0);
		hold_until_settled();

		// --- random part ---
		// Reduces of fresh rows and of XOR mixes of earlier rows (long
		// chains, dependent rows), plus loads, reads and undefined ops.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			quiet     = (i >= RANDOM_REQUESTS - QUIET_TAIL);
			idle_odds = ((i / 128) % 3 == 0) ? 0 : 3;
			if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
				hold_until_settled();
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				issue(OP_REDUCE, shaped_row(), COL_W'($urandom));
			end else if (kind < 45) begin
				mix = '0;
				repeat ($urandom_range(1, 4))
					mix ^= row_history[$urandom_range(0, row_history.size() - 1)];
				if ($urandom_range(0, 3) == 0)
					mix ^= DATA_W'(1) << $urandom_range(0, DATA_W - 1);
				issue(OP_REDUCE, mix, COL_W'($urandom));
			end else if (kind < 60) begin
				issue(OP_LOAD, ($urandom_range(0, 29) == 0) ? '0 : shaped_row(),
					COL_W'($urandom));
			end else if (kind < 95) begin
				issue(OP_READ, {$urandom, $urandom}, COL_W'($urandom_range(0, 63)));
			end else begin
				issue(OP_UNDEF, {$urandom, $urandom}, COL_W'($urandom));
			end
		end

		hold_until_settled();
		repeat (ROW_BITS + 16) @(negedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gf2re_pkg.sv
sv/gf2re_chan_if.sv
sv/gf2re_cell.sv
sv/gf2_row_elimination_top.sv
dv/gf2re_outcome_checker.sv
dv/testbench.sv
